### rtl/core/cps_pkg.sv
package cps_pkg;

	localparam int COORD_BITS  = 16;
	localparam int MAX_ROUNDS  = 4;
	localparam int ROUND_BITS  = 3;
	localparam int IDX_BITS    = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
	localparam int DATA_BITS   = 3 * COORD_BITS;
	localparam int TDATA_BITS  = ((DATA_BITS + 7) / 8) * 8;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	// x in the lowest bits
	typedef struct packed {
		coord_t z;
		coord_t y;
		coord_t x;
	} point_t;

	typedef struct packed {
		point_t pt;
		logic   last;
	} beat_t;

	// output phase of one cell
	typedef enum logic [1:0] {
		PH_NEAR_P = 2'd0,
		PH_NEAR_C = 2'd1,
		PH_COPY   = 2'd2,
		PH_END    = 2'd3
	} phase_t;

endpackage

### rtl/core/cps_cell.sv
module cps_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           clr,
	input  logic           in_valid,
	output logic           in_ready,
	input  cps_pkg::beat_t in_beat,
	output logic           out_valid,
	input  logic           out_ready,
	output cps_pkg::beat_t out_beat
);

	localparam int CB = cps_pkg::COORD_BITS;

	// floor((3a + b) / 4)
	function automatic cps_pkg::coord_t mix(input cps_pkg::coord_t a,
		input cps_pkg::coord_t b);
		logic signed [CB+1:0] ae;
		logic signed [CB+1:0] be;
		logic signed [CB+1:0] s;
		ae = {{2{a[CB-1]}}, a};
		be = {{2{b[CB-1]}}, b};
		s  = (ae <<< 1) + ae + be;
		return s[CB+1:2];
	endfunction

	cps_pkg::point_t held_q;
	logic            hvalid_q;
	cps_pkg::point_t p_q;
	cps_pkg::point_t c_q;
	logic            last_q;
	logic            busy_q;
	cps_pkg::phase_t phase_q;
	cps_pkg::phase_t phase_d;

	logic done;
	logic in_fire;
	logic out_fire;

	assign done      = last_q ? (phase_q == cps_pkg::PH_END) : (phase_q == cps_pkg::PH_NEAR_C);
	assign out_valid = busy_q;
	assign out_fire  = busy_q && out_ready;
	assign in_ready  = !busy_q || (out_ready && done);
	assign in_fire   = in_valid && in_ready;

	always_comb begin
		phase_d = phase_q;
		if (in_fire) begin
			phase_d = hvalid_q ? cps_pkg::PH_NEAR_P : cps_pkg::PH_COPY;
		end else if (out_fire && !done) begin
			phase_d = cps_pkg::phase_t'(phase_q + 2'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvalid_q <= 1'b0;
			busy_q   <= 1'b0;
			phase_q  <= cps_pkg::PH_NEAR_P;
		end else begin
			phase_q <= phase_d;
			if (in_fire) begin
				hvalid_q <= !in_beat.last;
				busy_q   <= hvalid_q || in_beat.last;
			end else if (out_fire && done) begin
				busy_q <= 1'b0;
			end
			if (clr) begin
				hvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			held_q <= in_beat.pt;
			p_q    <= held_q;
			c_q    <= in_beat.pt;
			last_q <= in_beat.last;
		end
	end

	always_comb begin
		out_beat.last = last_q && (phase_q == cps_pkg::PH_END);
		unique case (phase_q)
			cps_pkg::PH_NEAR_P: begin
				out_beat.pt.x = mix(p_q.x, c_q.x);
				out_beat.pt.y = mix(p_q.y, c_q.y);
				out_beat.pt.z = mix(p_q.z, c_q.z);
			end
			cps_pkg::PH_NEAR_C: begin
				out_beat.pt.x = mix(c_q.x, p_q.x);
				out_beat.pt.y = mix(c_q.y, p_q.y);
				out_beat.pt.z = mix(c_q.z, p_q.z);
			end
			default: begin
				out_beat.pt = c_q;
			end
		endcase
	end

endmodule

### rtl/core/chaikin_polyline_subdivision.sv
// Chaikin corner cutting on a stream of 3D points.
// s_axis carries one point per beat (x, y, z signed Q8.8, tlast on the final
// point of a polyline). m_axis returns the subdivided points, tlast on the
// final one. cfg_data sets the number of rounds (0..4, larger values act as
// 4); cfg_ready is always high and a write starts a new polyline. Write it
// only while no points are in flight.
// Each round is one cell in a chain. A cell emits two points per input pair
// and two copies of the last point, one beat per cycle while its output is
// ready, so a polyline of n points grows to n * 2^rounds points. The output
// side runs at one beat per cycle while m_axis_tready is high; a cell accepts
// its next point as the final beat for its current one leaves. An input beat
// passes through one register per active cell and then the output register.
// When m_axis_tready is low, the output register holds its beat and the stall
// backs up through the cells to s_axis_tready.
// Reset sets rounds to 1 and empties every cell.
module chaikin_polyline_subdivision (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [cps_pkg::TDATA_BITS-1:0]     s_axis_tdata,  // px, py, pz
	input  logic                               s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [cps_pkg::TDATA_BITS-1:0]     m_axis_tdata,  // qx, qy, qz
	output logic                               m_axis_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cps_pkg::ROUND_BITS-1:0]     cfg_data
);

	localparam int NR = cps_pkg::MAX_ROUNDS;
	localparam int RB = cps_pkg::ROUND_BITS;

	logic [RB-1:0]  rnd_q;
	logic           clr;

	cps_pkg::beat_t in_beat;
	cps_pkg::beat_t cbeat_out [NR];
	logic [NR-1:0]  cvld_out;
	logic [NR-1:0]  crdy_in;
	logic [NR-1:0]  crdy_out;

	logic           sel_vld;
	cps_pkg::beat_t sel_beat;
	logic           ordy;
	logic           ovld_q;
	cps_pkg::beat_t obeat_q;
	logic [cps_pkg::IDX_BITS-1:0] sel_idx;

	assign cfg_ready = 1'b1;
	assign clr       = cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= RB'(1);
		end else if (cfg_valid) begin
			rnd_q <= (cfg_data > RB'(NR)) ? RB'(NR) : cfg_data;
		end
	end

	assign in_beat.pt   = s_axis_tdata[cps_pkg::DATA_BITS-1:0];
	assign in_beat.last = s_axis_tlast;

	genvar i;
	generate
		for (i = 0; i < NR; i++) begin : g_cell
			logic           vin;
			cps_pkg::beat_t bin;
			if (i == 0) begin : g_head
				assign vin = s_axis_tvalid && (rnd_q > RB'(i));
				assign bin = in_beat;
			end else begin : g_link
				assign vin = cvld_out[i-1] && (rnd_q > RB'(i));
				assign bin = cbeat_out[i-1];
			end
			if (i == NR - 1) begin : g_tail
				assign crdy_out[i] = ordy;
			end else begin : g_mid
				assign crdy_out[i] = (rnd_q == RB'(i + 1)) ? ordy : crdy_in[i+1];
			end

			cps_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.clr       (clr),
				.in_valid  (vin),
				.in_ready  (crdy_in[i]),
				.in_beat   (bin),
				.out_valid (cvld_out[i]),
				.out_ready (crdy_out[i]),
				.out_beat  (cbeat_out[i])
			);
		end
	endgenerate

	assign sel_idx = cps_pkg::IDX_BITS'(rnd_q - RB'(1));

	always_comb begin
		if (rnd_q == '0) begin
			sel_vld       = s_axis_tvalid;
			sel_beat      = in_beat;
			s_axis_tready = ordy;
		end else begin
			sel_vld       = cvld_out[sel_idx];
			sel_beat      = cbeat_out[sel_idx];
			s_axis_tready = crdy_in[0];
		end
	end

	// single output register, refilled in the cycle it drains
	assign ordy = !ovld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (ordy) begin
			ovld_q <= sel_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ordy && sel_vld) begin
			obeat_q <= sel_beat;
		end
	end

	assign m_axis_tvalid = ovld_q;
	assign m_axis_tdata  = cps_pkg::TDATA_BITS'(obeat_q.pt);
	assign m_axis_tlast  = obeat_q.last;

	a_rounds_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_q <= RB'(NR))
		else $error("round count above maximum");

	a_unused_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cvld_out >> rnd_q) == '0)
		else $error("cell beyond active round count holds a beat");

	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && rnd_q == '0) |=>
			(m_axis_tvalid && m_axis_tdata == $past(s_axis_tdata)
				&& m_axis_tlast == $past(s_axis_tlast)))
		else $error("bypass beat not forwarded");

endmodule
